FILE: hw/rtl/bupl_pkg.sv
// Shared constants, types and blend arithmetic for the bilinear palette scaler.
`default_nettype none
package bupl_pkg;

  // Default geometry
  localparam int unsigned DEF_FIELD_WIDTH  = 320;
  localparam int unsigned DEF_FIELD_HEIGHT = 240;
  localparam int unsigned DEF_PALETTE_SIZE = 4096;

  // Action codes of an input word
  localparam logic [1:0] ACT_FIELD_WR = 2'd0;
  localparam logic [1:0] ACT_PAL_WR   = 2'd1;
  localparam logic [1:0] ACT_RENDER   = 2'd2;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_OUT_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_OUT_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PAL_OFFSET = 2'd2;

  // Configuration reset values
  localparam logic [12:0] RST_OUT_WIDTH  = 13'd320;
  localparam logic [12:0] RST_OUT_HEIGHT = 13'd240;
  localparam logic [11:0] RST_PAL_OFFSET = 12'd0;

  // Field store access control for one pipeline slot
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // p + floor(((q - p) * f) / 256), an arithmetic shift by 8
  function automatic logic [15:0] blend(input logic [15:0] p, input logic [15:0] q,
                                        input logic [7:0] f);
    logic signed [16:0] diff;
    logic signed [25:0] prod;
    logic signed [17:0] sum;
    diff = $signed({1'b0, q}) - $signed({1'b0, p});
    prod = diff * $signed({1'b0, f});
    sum  = $signed({2'b00, p}) + prod[25:8];
    return sum[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bupl_div.sv
// Restoring divider: fixed dividend by a 13-bit register minus one (at least one), one quotient bit per cycle.
`default_nettype none
module bupl_div #(
  parameter int unsigned DIVIDEND = 20905983,
  parameter int unsigned QW       = 26
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [12:0]   divisor,
  output logic               busy,
  output logic [QW-1:0]      quotient
);
  import bupl_pkg::*;

  localparam int unsigned CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [13:0]   rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [12:0]   div_r, div_nxt;
  logic [13:0]   trial;

  // Shift in one dividend bit and subtract when it fits
  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    div_nxt = div_r;
    trial   = {rem_r[12:0], q_r[QW-1]};
    if (start) begin
      cnt_nxt = CW'(QW);
      rem_nxt = '0;
      q_nxt   = QW'(DIVIDEND);
      div_nxt = (divisor > 13'd1) ? divisor - 13'd1 : 13'd1;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    div_r <= div_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QW)) else $error("divider count out of range");
  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy) else $error("divider did not start");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !start |=> cnt_r == $past(cnt_r) - CW'(1)) else $error("divider count slip");

endmodule
`default_nettype wire

FILE: hw/rtl/bupl_field_mem.sv
// Field sample store: two copies, each with two read ports, for the four neighbors.
`default_nettype none
module bupl_field_mem #(
  parameter int unsigned FIELD_WIDTH  = 320,
  parameter int unsigned FIELD_HEIGHT = 240,
  localparam int unsigned DEPTH = FIELD_WIDTH * FIELD_HEIGHT,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire bupl_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [15:0]        wr_data,
  input  wire logic [AW-1:0]      rd_addr,
  output logic [15:0]             q00,
  output logic [15:0]             q01,
  output logic [15:0]             q10,
  output logic [15:0]             q11
);
  import bupl_pkg::*;

  logic [15:0] mem_top [DEPTH];
  logic [15:0] mem_bot [DEPTH];
  logic [AW-1:0] a01, a10, a11;

  // Neighbor addresses: right, below, below right
  assign a01 = rd_addr + AW'(1);
  assign a10 = rd_addr + AW'(FIELD_WIDTH);
  assign a11 = rd_addr + AW'(FIELD_WIDTH + 1);

  // Upper row copy
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_top[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q00 <= mem_top[rd_addr];
      q01 <= mem_top[a01];
    end
  end

  // Lower row copy
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_bot[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q10 <= mem_bot[a10];
      q11 <= mem_bot[a11];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bilinear_upscale_palette_lookup_top.sv
// Bilinear upscaler with palette lookup: top level, seven-stage pipeline.
//
// Input words carry an action: write a field sample, write a palette entry or
// render one output pixel (out_x, out_y). Only renders return a word on the
// out_ channel (pixel_color). Words are taken when in_valid is high and
// in_stall low; results leave when out_valid is high and out_stall low. The user
// writes the configuration (out_width, out_height, palette_offset) on the cfg_
// channel only while the block is idle (not enforced). cfg_ready is always high.
//
// Throughput: one word per clock while in_stall stays low. A render passes stages
// 1 to 7 to out_valid (field read at stage 4, palette read at stage 7). Writes
// and renders stay in order, so a render sees every write accepted before it.
// The XW.16 and YW.16 source steps come from two bit-serial dividers: after reset
// and after each write to out_width or out_height, in_stall stays high while the
// steps are recomputed.
// When out_stall is high the output register holds; stages behind it keep
// filling their empty slots before in_stall rises. Reset clears all valid bits.
`default_nettype none
module bilinear_upscale_palette_lookup_top #(
  parameter int unsigned FIELD_WIDTH  = bupl_pkg::DEF_FIELD_WIDTH,
  parameter int unsigned FIELD_HEIGHT = bupl_pkg::DEF_FIELD_HEIGHT,
  parameter int unsigned PALETTE_SIZE = bupl_pkg::DEF_PALETTE_SIZE
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [16:0] in_field_address,
  input  wire logic [15:0] in_field_value,
  input  wire logic [11:0] in_palette_index,
  input  wire logic [31:0] in_palette_color,
  input  wire logic [11:0] in_out_x,
  input  wire logic [11:0] in_out_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_pixel_color,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import bupl_pkg::*;

  localparam int unsigned DEPTH = FIELD_WIDTH * FIELD_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(FIELD_WIDTH);
  localparam int unsigned YW    = $clog2(FIELD_HEIGHT);
  localparam int unsigned SXW   = XW + 16;
  localparam int unsigned SYW   = YW + 16;
  localparam int unsigned NX    = ((FIELD_WIDTH - 1) << 16) - 1;
  localparam int unsigned NY    = ((FIELD_HEIGHT - 1) << 16) - 1;
  localparam int unsigned PW    = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

  // Configuration registers
  logic [12:0] out_width_r, out_height_r;
  logic [11:0] pal_offset_r;
  logic        start_r;
  logic        busy_x, busy_y;
  logic [SXW-1:0] step_x;
  logic [SYW-1:0] step_y;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= RST_OUT_WIDTH;
      out_height_r <= RST_OUT_HEIGHT;
      pal_offset_r <= RST_PAL_OFFSET;
      start_r      <= 1'b1;
    end else begin
      start_r <= cfg_wr && (cfg_index == CFG_OUT_WIDTH || cfg_index == CFG_OUT_HEIGHT);
      if (cfg_wr) begin
        case (cfg_index)
          CFG_OUT_WIDTH:  out_width_r  <= cfg_data;
          CFG_OUT_HEIGHT: out_height_r <= cfg_data;
          CFG_PAL_OFFSET: pal_offset_r <= cfg_data[11:0];
          default: ;
        endcase
      end
    end
  end

  // Step dividers, one per axis
  bupl_div #(.DIVIDEND(NX), .QW(SXW)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(start_r), .divisor(out_width_r),
    .busy(busy_x), .quotient(step_x)
  );
  bupl_div #(.DIVIDEND(NY), .QW(SYW)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(start_r), .divisor(out_height_r),
    .busy(busy_y), .quotient(step_y)
  );

  // Stage valid bits and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;
  logic in_acc;

  assign ld7 = !v7_r || !out_stall;
  assign ld6 = !v6_r || ld7;
  assign ld5 = !v5_r || ld6;
  assign ld4 = !v4_r || ld5;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_stall = !ld1 || busy_x || busy_y || start_r;
  assign in_acc   = in_valid && !in_stall;

  // Stage payloads
  logic [1:0]  act1_r, act2_r, act3_r, act4_r, act5_r, act6_r;
  logic [16:0] faddr1_r, faddr2_r, faddr3_r;
  logic [15:0] fval1_r, fval2_r, fval3_r;
  logic [11:0] pidx1_r, pidx2_r, pidx3_r, pidx4_r, pidx5_r, pidx6_r;
  logic [31:0] pcol1_r, pcol2_r, pcol3_r, pcol4_r, pcol5_r, pcol6_r;
  logic [11:0] cx1_r, cy1_r;
  logic [SXW+11:0] ax2_r;
  logic [SYW+11:0] ay2_r;
  logic [AW-1:0] idx3_r;
  logic [7:0]  fx3_r, fy3_r, fx4_r, fy4_r, fy5_r;
  logic [15:0] top5_r, bot5_r;
  logic [PW-1:0] prd6_r;

  // Stage 1: clamp coordinates into the frame
  logic [12:0] lim_x, lim_y;
  logic [11:0] cx_nxt, cy_nxt;
  assign lim_x  = (out_width_r  > 13'd1) ? out_width_r  - 13'd1 : 13'd0;
  assign lim_y  = (out_height_r > 13'd1) ? out_height_r - 13'd1 : 13'd0;
  assign cx_nxt = ({1'b0, in_out_x} > lim_x) ? lim_x[11:0] : in_out_x;
  assign cy_nxt = ({1'b0, in_out_y} > lim_y) ? lim_y[11:0] : in_out_y;

  always_ff @(posedge clk) begin
    if (ld1) begin
      act1_r   <= in_action;
      faddr1_r <= in_field_address;
      fval1_r  <= in_field_value;
      pidx1_r  <= in_palette_index;
      pcol1_r  <= in_palette_color;
      cx1_r    <= cx_nxt;
      cy1_r    <= cy_nxt;
    end
  end

  // Stage 2: scale by the source step
  always_ff @(posedge clk) begin
    if (ld2) begin
      act2_r   <= act1_r;
      faddr2_r <= faddr1_r;
      fval2_r  <= fval1_r;
      pidx2_r  <= pidx1_r;
      pcol2_r  <= pcol1_r;
      ax2_r    <= step_x * cx1_r;
      ay2_r    <= step_y * cy1_r;
    end
  end

  // Stage 3: integer position, fraction and row-major base address
  logic [SXW-5:0] posx_full;
  logic [SYW-5:0] posy_full;
  logic [XW-1:0]  ix;
  logic [YW-1:0]  iy;
  logic [AW-1:0]  idx_nxt;
  assign posx_full = ax2_r[SXW+11:16];
  assign posy_full = ay2_r[SYW+11:16];
  assign ix = (posx_full > (SXW-4)'(FIELD_WIDTH - 2))  ? XW'(FIELD_WIDTH - 2)
                                                       : posx_full[XW-1:0];
  assign iy = (posy_full > (SYW-4)'(FIELD_HEIGHT - 2)) ? YW'(FIELD_HEIGHT - 2)
                                                       : posy_full[YW-1:0];
  assign idx_nxt = AW'(iy) * AW'(FIELD_WIDTH) + AW'(ix);

  always_ff @(posedge clk) begin
    if (ld3) begin
      act3_r   <= act2_r;
      faddr3_r <= faddr2_r;
      fval3_r  <= fval2_r;
      pidx3_r  <= pidx2_r;
      pcol3_r  <= pcol2_r;
      idx3_r   <= idx_nxt;
      fx3_r    <= ax2_r[15:8];
      fy3_r    <= ay2_r[15:8];
    end
  end

  // Stage 4: field store write or four-neighbor read
  mem_ctl_t fctl;
  logic [15:0] q00, q01, q10, q11;
  assign fctl.rd_en = ld4;
  assign fctl.wr_en = ld4 && v3_r && (act3_r == ACT_FIELD_WR) &&
                      ({15'd0, faddr3_r} < 32'(DEPTH));

  bupl_field_mem #(.FIELD_WIDTH(FIELD_WIDTH), .FIELD_HEIGHT(FIELD_HEIGHT)) u_field (
    .clk(clk), .ctl(fctl), .wr_addr(AW'(faddr3_r)), .wr_data(fval3_r),
    .rd_addr(idx3_r), .q00(q00), .q01(q01), .q10(q10), .q11(q11)
  );

  always_ff @(posedge clk) begin
    if (ld4) begin
      act4_r  <= act3_r;
      pidx4_r <= pidx3_r;
      pcol4_r <= pcol3_r;
      fx4_r   <= fx3_r;
      fy4_r   <= fy3_r;
    end
  end

  // Stage 5: horizontal blend
  always_ff @(posedge clk) begin
    if (ld5) begin
      act5_r  <= act4_r;
      pidx5_r <= pidx4_r;
      pcol5_r <= pcol4_r;
      fy5_r   <= fy4_r;
      top5_r  <= blend(q00, q01, fx4_r);
      bot5_r  <= blend(q10, q11, fx4_r);
    end
  end

  // Stage 6: vertical blend, offset and palette mask
  logic [15:0] vb;
  logic [16:0] psum;
  logic [31:0] pmask;
  assign vb    = blend(top5_r, bot5_r, fy5_r);
  assign psum  = {1'b0, vb} + {5'd0, pal_offset_r};
  assign pmask = {15'd0, psum} & (PALETTE_SIZE - 1);

  always_ff @(posedge clk) begin
    if (ld6) begin
      act6_r  <= act5_r;
      pidx6_r <= pidx5_r;
      pcol6_r <= pcol5_r;
      prd6_r  <= (pmask >= 32'(PALETTE_SIZE)) ? '0 : PW'(pmask);
    end
  end

  // Stage 7: palette write or color read into the output register
  logic [31:0] pal_mem [PALETTE_SIZE];
  logic        pal_we;
  assign pal_we = ld7 && v6_r && (act6_r == ACT_PAL_WR) &&
                  ({20'd0, pidx6_r} < 32'(PALETTE_SIZE));

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[PW'(pidx6_r)] <= pcol6_r;
    end
    if (ld7) begin
      out_pixel_color <= pal_mem[prd6_r];
    end
  end

  // Advance valid bits; drop all but renders at the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_acc;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
      if (ld6) v6_r <= v5_r;
      if (ld7) v7_r <= v6_r && (act6_r == ACT_RENDER);
    end
  end

  assign out_valid = v7_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_x || busy_y) |-> !in_acc) else $error("word taken during step update");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && act3_r == ACT_RENDER |-> 32'(idx3_r) <= 32'(DEPTH - FIELD_WIDTH - 2))
    else $error("neighbor address outside field");
  a_pal_range: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> 32'(prd6_r) < 32'(PALETTE_SIZE)) else $error("palette index out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r && out_stall |=> v7_r && $stable(out_pixel_color))
    else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Testbench for the bilinear upscaler with palette lookup: in-order prediction and output checks.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bupl_pkg::*;

  localparam int unsigned FW = DEF_FIELD_WIDTH;
  localparam int unsigned FH = DEF_FIELD_HEIGHT;
  localparam int unsigned PS = DEF_PALETTE_SIZE;
  localparam int unsigned FDEPTH = FW * FH;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [1:0]  action;
    logic [16:0] field_address;
    logic [15:0] field_value;
    logic [11:0] palette_index;
    logic [31:0] palette_color;
    logic [11:0] out_x;
    logic [11:0] out_y;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [16:0] in_field_address = '0;
  logic [15:0] in_field_value = '0;
  logic [11:0] in_palette_index = '0;
  logic [31:0] in_palette_color = '0;
  logic [11:0] in_out_x = '0;
  logic [11:0] in_out_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_pixel_color;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  bilinear_upscale_palette_lookup_top dut (.*);

  always #6 clk = ~clk;

  // Shadow copy of the block state
  logic [15:0] field_mem [FDEPTH];
  bit          field_seen [FDEPTH];
  logic [31:0] pal_mem [PS];
  bit          pal_seen [PS];
  logic [12:0] width_reg = RST_OUT_WIDTH;
  logic [12:0] height_reg = RST_OUT_HEIGHT;
  logic [11:0] offset_reg = RST_PAL_OFFSET;

  word_t       pending_words [$];
  logic [31:0] expected_colors [$];
  int          errors = 0;
  int          n_renders = 0;
  int          n_writes = 0;
  int          n_checked = 0;
  bit          hold_req = 1'b0;

  function automatic word_t rand_word();
    word_t w;
    w.action        = ACT_FIELD_WR;
    w.field_address = 17'($urandom_range(0, 17'h1FFFF));
    w.field_value   = 16'($urandom);
    w.palette_index = 12'($urandom);
    w.palette_color = $urandom;
    w.out_x         = 12'($urandom);
    w.out_y         = 12'($urandom);
    return w;
  endfunction

  // Integer position and fraction along one axis
  function automatic void locate(input int unsigned coord, input int unsigned size,
                                 input int unsigned src, output int unsigned pos,
                                 output int unsigned frac);
    int unsigned divisor, lim, step;
    longint unsigned prod;
    divisor = (size > 1) ? size - 1 : 1;
    lim     = (size > 1) ? size - 1 : 0;
    step    = (((src - 1) << 16) - 1) / divisor;
    if (coord > lim) coord = lim;
    prod = longint'(step) * longint'(coord);
    pos  = int'(prod >> 16);
    frac = int'((prod >> 8) & 255);
    if (pos > src - 2) pos = src - 2;
  endfunction

  function automatic longint mix(input longint p, input longint q, input int unsigned f);
    longint t;
    t = (q - p) * longint'(f);
    return p + (t >>> 8);
  endfunction

  // Update shadow state for a write and queue the word
  function automatic void push_write(input word_t w);
    if (w.action == ACT_FIELD_WR && w.field_address < FDEPTH) begin
      field_mem[w.field_address]  = w.field_value;
      field_seen[w.field_address] = 1'b1;
    end else if (w.action == ACT_PAL_WR) begin
      pal_mem[w.palette_index]  = w.palette_color;
      pal_seen[w.palette_index] = 1'b1;
    end
    n_writes++;
    pending_words.push_back(w);
  endfunction

  function automatic void fill_field(input int unsigned a);
    word_t w;
    if (!field_seen[a]) begin
      w = rand_word();
      w.action = ACT_FIELD_WR;
      w.field_address = 17'(a);
      push_write(w);
    end
  endfunction

  // Queue a render, first writing any entry it would read that holds nothing yet
  function automatic void push_render(input int unsigned x, input int unsigned y);
    word_t w;
    int unsigned ix, fx, iy, fy, pidx, a;
    longint top, bot, v;
    locate(x, width_reg, FW, ix, fx);
    locate(y, height_reg, FH, iy, fy);
    a = iy * FW + ix;
    fill_field(a);
    fill_field(a + 1);
    fill_field(a + FW);
    fill_field(a + FW + 1);
    top = mix(field_mem[a], field_mem[a + 1], fx);
    bot = mix(field_mem[a + FW], field_mem[a + FW + 1], fx);
    v = mix(top, bot, fy);
    pidx = (int'(v) + offset_reg) & (PS - 1);
    if (!pal_seen[pidx]) begin
      w = rand_word();
      w.action = ACT_PAL_WR;
      w.palette_index = 12'(pidx);
      push_write(w);
    end
    w = rand_word();
    w.action = ACT_RENDER;
    w.out_x = 12'(x);
    w.out_y = 12'(y);
    n_renders++;
    pending_words.push_back(w);
    expected_colors.push_back(pal_mem[pidx]);
  endfunction

  function automatic int unsigned rand_coord();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(0, 7);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // Driver: bursts of words with random gaps, payload held while stalled
  bit    in_taken = 1'b0;
  bit    word_live = 1'b0;
  int    gap_left = 0;
  int    burst_left = 0;
  word_t cur_word;

  always @(posedge clk) in_taken = in_valid && !in_stall;

  always @(negedge clk) begin
    if (in_taken) word_live = 1'b0;
    if (!word_live) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        word_live = 1'b1;
        in_action        <= cur_word.action;
        in_field_address <= cur_word.field_address;
        in_field_value   <= cur_word.field_value;
        in_palette_index <= cur_word.palette_index;
        in_palette_color <= cur_word.palette_color;
        in_out_x         <= cur_word.out_x;
        in_out_y         <= cur_word.out_y;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid <= word_live;
  end

  // Receiver: stall density changes over time, plus one long hold-off
  int  cyc = 0;
  int  hold_left = 0;
  int  stall_pct = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    cyc++;
    if (cyc % 256 == 0) stall_pct = $urandom_range(0, 3) * 20;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected pixel_color %h", $realtime, out_pixel_color);
        errors++;
      end else begin
        if (out_pixel_color !== expected_colors[0]) begin
          $display("%0t: pixel_color expected %h actual %h", $realtime,
                   expected_colors[0], out_pixel_color);
          errors++;
        end
        void'(expected_colors.pop_front());
        n_checked++;
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() > 0 || word_live || expected_colors.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OUT_WIDTH:  width_reg = val;
      CFG_OUT_HEIGHT: height_reg = val;
      CFG_PAL_OFFSET: offset_reg = val[11:0];
      default: ;
    endcase
  endtask

  task automatic random_phase(input int count);
    word_t w;
    int start;
    start = n_renders + n_writes;
    while (n_renders + n_writes - start < count) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          w = rand_word();
          w.action = ACT_FIELD_WR;
          push_write(w);
        end
        3, 4: begin
          w = rand_word();
          w.action = ACT_PAL_WR;
          push_write(w);
        end
        5: begin
          w = rand_word();
          w.action = ACT_UNUSED;
          pending_words.push_back(w);
        end
        default: push_render(rand_coord(), rand_coord());
      endcase
    end
  endtask

  // Stimulus: directed words, then random phases under several settings
  initial begin
    word_t w;
    logic [12:0] widths  [6] = '{13'd1, 13'd4096, 13'd640, 13'd2, 13'd100, 13'd320};
    logic [12:0] heights [6] = '{13'd1, 13'd4096, 13'd480, 13'd3, 13'd4096, 13'd240};
    logic [12:0] offsets [6] = '{13'd4095, 13'd0, 13'd1234, 13'd4000, 13'd7, 13'd0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field and palette extremes, unused action, out-of-range writes
    w = rand_word(); w.field_address = 17'd0;  w.field_value = 16'h0000; push_write(w);
    w = rand_word(); w.field_address = 17'd1;  w.field_value = 16'hFFFF; push_write(w);
    w = rand_word(); w.field_address = 17'(FW); w.field_value = 16'hFFFF; push_write(w);
    w = rand_word(); w.field_address = 17'(FW + 1); w.field_value = 16'h0000; push_write(w);
    w = rand_word(); w.field_address = 17'(FDEPTH - 1);  push_write(w);
    w = rand_word(); w.field_address = 17'(FDEPTH);      push_write(w);
    w = rand_word(); w.field_address = 17'h1FFFF;  push_write(w);
    w = rand_word(); w.action = ACT_PAL_WR; w.palette_index = 12'd0;
    w.palette_color = 32'h0; push_write(w);
    w = rand_word(); w.action = ACT_PAL_WR; w.palette_index = 12'hFFF;
    w.palette_color = 32'hFFFF_FFFF; push_write(w);
    w = rand_word(); w.action = ACT_UNUSED; pending_words.push_back(w);
    push_render(0, 0);
    push_render(1, 1);
    push_render(319, 239);
    push_render(320, 240);
    push_render(4095, 4095);
    push_render(4095, 0);
    push_render(0, 4095);
    random_phase(200);
    wait_idle();

    foreach (widths[i]) begin
      write_reg(CFG_OUT_WIDTH, widths[i]);
      write_reg(CFG_OUT_HEIGHT, heights[i]);
      write_reg(CFG_PAL_OFFSET, offsets[i]);
      if (i == 2) hold_req = 1'b1;
      push_render(0, 0);
      push_render(4095, 4095);
      random_phase(150);
      wait_idle();
    end

    if (expected_colors.size() != 0) begin
      $display("%0t: %0d pixel colors never arrived", $realtime, expected_colors.size());
      errors++;
    end
    $display("Ran %0d renders and %0d writes over 7 settings, checked %0d pixels, %0d errors.",
             n_renders, n_writes, n_checked, errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
